[rtl/core/gps_pkg.sv]
// ============================================================================
// gps_pkg
// Shared types and codes for the grab / push / stamp sequencer.
// ============================================================================
package gps_pkg;

    // Machine states. Codes six and seven are never entered.
    typedef enum logic [2:0] {
        ST_FAULT     = 3'd0,
        ST_QUIET     = 3'd1,
        ST_GRAB      = 3'd2,
        ST_PUSH      = 3'd3,
        ST_STAMP     = 3'd4,
        ST_STAMPGRAB = 3'd5
    } t_gps_mstate;

    // Request kinds (carried on tuser).
    localparam logic [1:0] REQ_CMD   = 2'd0;
    localparam logic [1:0] REQ_REPLY = 2'd1;

    // Host commands.
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_STOP   = 2'd1;
    localparam logic [1:0] CMD_REPORT = 2'd2;

    // Reply senders.
    localparam logic [1:0] FROM_GRABBER = 2'd0;
    localparam logic [1:0] FROM_PUSHER  = 2'd1;
    localparam logic [1:0] FROM_STAMPER = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNHANDLED = 2'd1;
    localparam logic [1:0] ERR_BADCMD    = 2'd2;
    localparam logic [1:0] ERR_BADSTATE  = 2'd3;

    localparam int REQ_DATA_W = 8;
    localparam int RES_W      = 10;
    localparam int RES_DATA_W = 16;

    // One request; the low eight bits are the tdata fields, req_type on top.
    typedef struct packed {
        logic [1:0] req_type;
        logic       emergency_stop;
        logic       air_pressure;
        logic       reply_ok;
        logic [1:0] reply_from;
        logic       continuous_req;
        logic [1:0] command;
    } t_gps_req;

    // One result, packed as it appears on the output tdata (issue_grab at bit 0).
    typedef struct packed {
        logic       report_valid;
        logic [2:0] state_report;
        logic [1:0] error_code;
        logic       reset_all;
        logic       issue_stamp;
        logic       issue_push;
        logic       issue_grab;
    } t_gps_result;

    // Sequencer context kept between requests.
    typedef struct packed {
        t_gps_mstate mstate;
        logic        continuous_mode;
        logic        stamper_done_ok;
        logic        grabber_done_ok;
    } t_gps_ctx;

endpackage

[rtl/core/gps_step.sv]
// ============================================================================
// gps_step
// Combinational step: interlock check, then request handling by state.
// ============================================================================
module gps_step
    import gps_pkg::*;
(
    input  t_gps_req    i_req,
    input  t_gps_ctx    i_ctx,
    output t_gps_ctx    o_ctx,
    output t_gps_result o_result
);

    logic     w_safe;
    t_gps_ctx w_mid;
    logic     w_lock_rst;
    logic     w_bad_state;
    logic     w_is_cmd;
    logic     w_is_reply;
    logic     w_active;
    logic     w_sg_stamp_ok;
    logic     w_sg_grab_ok;

    assign w_safe     = i_req.air_pressure && !i_req.emergency_stop;
    assign w_is_cmd   = (i_req.req_type == REQ_CMD);
    assign w_is_reply = (i_req.req_type == REQ_REPLY);

    // Interlock check on the air and e-stop inputs.
    always_comb begin
        w_mid       = i_ctx;
        w_lock_rst  = 1'b0;
        w_bad_state = 1'b0;
        unique case (i_ctx.mstate)
            ST_FAULT: begin
                if (w_safe) begin
                    w_mid = '{ST_QUIET, 1'b0, 1'b0, 1'b0};
                end
            end
            ST_QUIET: begin
                if (!w_safe) begin
                    w_mid = '{ST_FAULT, 1'b0, 1'b0, 1'b0};
                end
            end
            ST_GRAB, ST_PUSH, ST_STAMP, ST_STAMPGRAB: begin
                if (!w_safe) begin
                    w_mid.mstate = ST_FAULT;
                    w_lock_rst   = 1'b1;
                end
            end
            default: begin
                w_mid.mstate = ST_FAULT;
                w_bad_state  = 1'b1;
            end
        endcase
    end

    assign w_active = (w_mid.mstate != ST_FAULT) && (w_mid.mstate != ST_QUIET);

    // Done flags as they stand after a reply in stamp-and-grab.
    assign w_sg_stamp_ok = (i_req.reply_from == FROM_STAMPER) ? i_req.reply_ok
                                                                : w_mid.stamper_done_ok;
    assign w_sg_grab_ok  = (i_req.reply_from == FROM_GRABBER) ? i_req.reply_ok
                                                                : w_mid.grabber_done_ok;

    // Next state and flags.
    always_comb begin
        o_ctx = w_mid;
        if (w_is_cmd && (i_req.command != CMD_REPORT)) begin
            if (w_mid.mstate == ST_QUIET) begin
                if (i_req.command == CMD_START) begin
                    o_ctx.continuous_mode = i_req.continuous_req;
                    o_ctx.mstate          = ST_GRAB;
                end
            end else if (w_active && (i_req.command == CMD_STOP)) begin
                o_ctx = '{ST_QUIET, 1'b0, 1'b0, 1'b0};
            end
        end else if (w_is_reply) begin
            unique case (w_mid.mstate)
                ST_GRAB: begin
                    if ((i_req.reply_from == FROM_GRABBER) && i_req.reply_ok) begin
                        o_ctx.mstate = ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if ((i_req.reply_from == FROM_PUSHER) && i_req.reply_ok) begin
                        if (w_mid.continuous_mode) begin
                            o_ctx.stamper_done_ok = 1'b0;
                            o_ctx.grabber_done_ok = 1'b0;
                            o_ctx.mstate          = ST_STAMPGRAB;
                        end else begin
                            o_ctx.mstate = ST_STAMP;
                        end
                    end
                end
                ST_STAMP: begin
                    if ((i_req.reply_from == FROM_STAMPER) && i_req.reply_ok) begin
                        o_ctx = '{ST_QUIET, 1'b0, 1'b0, 1'b0};
                    end
                end
                ST_STAMPGRAB: begin
                    o_ctx.stamper_done_ok = w_sg_stamp_ok;
                    o_ctx.grabber_done_ok = w_sg_grab_ok;
                    if (w_sg_stamp_ok && w_sg_grab_ok) begin
                        o_ctx.mstate = ST_PUSH;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result fields.
    always_comb begin
        o_result              = '0;
        o_result.reset_all    = w_lock_rst;
        o_result.error_code   = w_bad_state ? ERR_BADSTATE : ERR_NONE;
        o_result.state_report = o_ctx.mstate;
        if (w_is_cmd) begin
            if (i_req.command == CMD_REPORT) begin
                o_result.report_valid = 1'b1;
            end else if (w_mid.mstate == ST_FAULT) begin
                if (i_req.command != CMD_STOP) begin
                    o_result.error_code = ERR_UNHANDLED;
                end
            end else if (w_mid.mstate == ST_QUIET) begin
                if (i_req.command == CMD_START) begin
                    o_result.issue_grab = 1'b1;
                end else begin
                    o_result.error_code = ERR_BADCMD;
                end
            end else if (i_req.command == CMD_STOP) begin
                o_result.reset_all = 1'b1;
            end else begin
                o_result.error_code = ERR_BADCMD;
            end
        end else if (w_is_reply) begin
            unique case (w_mid.mstate)
                ST_GRAB: begin
                    o_result.issue_push = (i_req.reply_from == FROM_GRABBER) && i_req.reply_ok;
                end
                ST_PUSH: begin
                    if ((i_req.reply_from == FROM_PUSHER) && i_req.reply_ok) begin
                        o_result.issue_stamp = 1'b1;
                        o_result.issue_grab  = w_mid.continuous_mode;
                    end
                end
                ST_STAMPGRAB: begin
                    o_result.issue_push = w_sg_stamp_ok && w_sg_grab_ok;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

[rtl/core/grab_push_stamp_sequencer.sv]
// ============================================================================
// grab_push_stamp_sequencer
// Sequencer for a grab / push / stamp part-handling machine.
// ============================================================================
// Usage:
// Requests enter on the s_axis channel. tuser carries req_type (host command,
// subsystem reply or sensor update); tdata carries command, continuous_req,
// reply_from, reply_ok, air_pressure and emergency_stop. Every request yields
// exactly one result on the m_axis channel with the actuator pulses
// (issue_grab, issue_push, issue_stamp, reset_all), an error code, the state
// reached and a report flag.
// A request is registered on acceptance, evaluated against the sequencer state
// once the result register is free or being emptied, and written to the result
// register together with the new state. While m_axis_tready is high, one request
// can be accepted every cycle; the rate is set by the single registered step
// through the interlock and state logic.
// After reset the sequencer is in the interlock fault state with all flags
// clear and both pipeline registers empty. When the receiver holds tready low,
// the result register holds its data and the input register can still take
// one more request; after that s_axis_tready drops until a result is taken.
// ============================================================================
module grab_push_stamp_sequencer
    import gps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, from bit 0: command[1:0], continuous_req, reply_from[1:0],
    // reply_ok, air_pressure, emergency_stop.
    input  logic [REQ_DATA_W-1:0] s_axis_tdata,
    // tuser: req_type[1:0].
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, from bit 0: issue_grab, issue_push, issue_stamp, reset_all,
    // error_code[1:0], state_report[2:0], report_valid, six zero bits.
    output logic [RES_DATA_W-1:0] m_axis_tdata
);

    logic        r_in_valid;
    t_gps_req    r_req;
    logic        r_out_valid;
    t_gps_result r_result;
    t_gps_ctx    r_ctx;

    t_gps_ctx    n_ctx;
    t_gps_result n_result;
    logic        w_advance;

    // The registered request moves forward whenever the result slot is free
    // or is being emptied in this cycle.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    gps_step u_step (
        .i_req    (r_req),
        .i_ctx    (r_ctx),
        .o_ctx    (n_ctx),
        .o_result (n_result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_req <= {s_axis_tuser, s_axis_tdata};
        end
    end

    // Sequencer state, updated once per evaluated request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx <= '{ST_FAULT, 1'b0, 1'b0, 1'b0};
        end else if (w_advance) begin
            r_ctx <= n_ctx;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(RES_DATA_W - RES_W){1'b0}}, r_result};

endmodule

[rtl/core/gps_checker.sv]
// ============================================================================
// gps_checker
// Port-level checks on the sequencer, bound to the top level.
// ============================================================================
module gps_checker
    import gps_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [RES_DATA_W-1:0] m_axis_tdata
);

    // A stalled result keeps its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No result is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A reported state is never one of the unused codes.
    a_state_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[8:6] != 3'd6) && (m_axis_tdata[8:6] != 3'd7))
        else $error("unused state code reported");

    // A state report never issues grab, push or stamp commands.
    a_report_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[9] |-> (m_axis_tdata[2:0] == 3'b000))
        else $error("actuator pulse with state report");

    // A stamp is only issued on the way into a stamping state.
    a_stamp_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |->
            (m_axis_tdata[8:6] == ST_STAMP) || (m_axis_tdata[8:6] == ST_STAMPGRAB))
        else $error("stamp issued outside a stamping state");

endmodule

bind grab_push_stamp_sequencer gps_checker u_gps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
